@@ sv/voa_pkg.sv @@
// Shared types, angle constants and the arctangent table for the vector angle core.
// No dependencies; every other source file depends on this package.
package voa_pkg;

    // Angle accumulator: degrees with 16 fractional bits, signed.
    localparam int ZW       = 26;
    localparam int ANGLE_W  = 16;
    localparam int SECT_W   = 3;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ZW-1:0] DEG90_Q16  = 26'sd5898240;
    localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;
    localparam logic signed [ZW-1:0] HALF_LSB   = 26'sd128;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX_Q8 = 16'd46080;
    localparam logic [ANGLE_W-1:0] SECT1_Q8     = 16'd5760;
    localparam logic [ANGLE_W-1:0] SECT2_Q8     = 16'd17280;
    localparam logic [ANGLE_W-1:0] SECT3_Q8     = 16'd28800;
    localparam logic [ANGLE_W-1:0] SECT4_Q8     = 16'd40320;

    // Sector codes
    localparam logic [SECT_W-1:0] SEC_NEAR      = 3'd0;
    localparam logic [SECT_W-1:0] SEC_ACUTE     = 3'd1;
    localparam logic [SECT_W-1:0] SEC_RIGHT     = 3'd2;
    localparam logic [SECT_W-1:0] SEC_OBTUSE    = 3'd3;
    localparam logic [SECT_W-1:0] SEC_OPPOSITE  = 3'd4;

    // Control that travels with each request down the pipeline.
    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

    // atan(2^-idx) in degrees, 16 fractional bits.
    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/voa_ifs.sv @@
// Request and result channel interfaces (valid/ready) for the vector angle core.
// Depends on voa_pkg for the result field widths.
interface voa_in_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface voa_out_if;
    logic                          valid;
    logic                          ready;
    logic [voa_pkg::ANGLE_W-1:0]   angle_deg;
    logic [voa_pkg::SECT_W-1:0]    sector;
    logic                          degenerate;

    modport source (output valid, angle_deg, sector, degenerate, input ready);
    modport sink   (input valid, angle_deg, sector, degenerate, output ready);
endinterface

@@ sv/voa_prep.sv @@
// Front end: products, dot and cross, then the start vector for the CORDIC chain.
// Two register stages. Depends on voa_pkg.
module voa_prep #(
    parameter int COORD_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [COORD_BITS-1:0]    i_sx,
    input  logic signed [COORD_BITS-1:0]    i_sy,
    input  logic signed [COORD_BITS-1:0]    i_ex,
    input  logic signed [COORD_BITS-1:0]    i_ey,
    output voa_pkg::t_ctl                   o_ctl,
    output logic signed [2*COORD_BITS+2:0]  o_x,
    output logic signed [2*COORD_BITS+2:0]  o_y,
    output logic signed [voa_pkg::ZW-1:0]   o_z
);
    import voa_pkg::*;

    localparam int PW = 2 * COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int XW = 2 * COORD_BITS + 3;

    t_ctl                  r_ctl_a, n_ctl_a;
    logic signed [PW-1:0]  r_sxex, r_syey, r_sxey, r_syex;
    t_ctl                  r_ctl_b;
    logic signed [XW-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0]  r_z, n_z;
    logic signed [DW-1:0]  w_dot, w_cross, w_abs;

    always_comb begin
        n_ctl_a.valid = i_valid;
        n_ctl_a.degen = ((i_sx == '0) && (i_sy == '0)) || ((i_ex == '0) && (i_ey == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
        end else if (i_en) begin
            r_ctl_a <= n_ctl_a;
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sxex <= i_sx * i_ex;
            r_syey <= i_sy * i_ey;
            r_sxey <= i_sx * i_ey;
            r_syex <= i_sy * i_ex;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    always_comb begin
        w_dot   = DW'(r_sxex) + DW'(r_syey);
        w_cross = DW'(r_sxey) - DW'(r_syex);
        w_abs   = w_cross[DW-1] ? -w_cross : w_cross;
        // Turn a obtuse pair by 90 degrees so the chain starts in the right half plane
        if (w_dot[DW-1]) begin
            n_x = XW'(w_abs);
            n_y = -XW'(w_dot);
            n_z = DEG90_Q16;
        end else begin
            n_x = XW'(w_dot);
            n_y = XW'(w_abs);
            n_z = '0;
        end
    end

    assign o_ctl = r_ctl_b;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

@@ sv/voa_cell.sv @@
// One CORDIC vectoring iteration with its own register stage.
// Depends on voa_pkg for the arctangent table and control struct.
module voa_cell #(
    parameter int XW   = 27,
    parameter int STEP = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  voa_pkg::t_ctl                  i_ctl,
    input  logic signed [XW-1:0]           i_x,
    input  logic signed [XW-1:0]           i_y,
    input  logic signed [voa_pkg::ZW-1:0]  i_z,
    output voa_pkg::t_ctl                  o_ctl,
    output logic signed [XW-1:0]           o_x,
    output logic signed [XW-1:0]           o_y,
    output logic signed [voa_pkg::ZW-1:0]  o_z
);
    import voa_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_STEP = atan_q16(STEP);

    t_ctl                 r_ctl;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y, w_xs, w_ys;
    logic signed [ZW-1:0] r_z, n_z;

    always_comb begin
        w_xs = i_x >>> STEP;
        w_ys = i_y >>> STEP;
        // Rotate toward the x axis: direction follows the sign of y
        if (!i_y[XW-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN_STEP;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

@@ sv/voa_post.sv @@
// Output stage: clamp, round to Q8.8, sector bands, result register.
// Depends on voa_pkg.
module voa_post (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  voa_pkg::t_ctl                  i_ctl,
    input  logic signed [voa_pkg::ZW-1:0]  i_z,
    output logic                           o_valid,
    output logic [voa_pkg::ANGLE_W-1:0]    o_angle,
    output logic [voa_pkg::SECT_W-1:0]     o_sector,
    output logic                           o_degen
);
    import voa_pkg::*;

    logic                 r_valid;
    logic [ANGLE_W-1:0]   r_angle, n_angle;
    logic [SECT_W-1:0]    r_sector, n_sector;
    logic                 r_degen;
    logic signed [ZW-1:0] w_zc, w_rnd;

    always_comb begin
        if (i_z[ZW-1]) begin
            w_zc = '0;
        end else if (i_z > DEG180_Q16) begin
            w_zc = DEG180_Q16;
        end else begin
            w_zc = i_z;
        end
        w_rnd   = w_zc + HALF_LSB;
        n_angle = w_rnd[ANGLE_W+7:8];

        if (n_angle < SECT1_Q8) begin
            n_sector = SEC_NEAR;
        end else if (n_angle < SECT2_Q8) begin
            n_sector = SEC_ACUTE;
        end else if (n_angle < SECT3_Q8) begin
            n_sector = SEC_RIGHT;
        end else if (n_angle < SECT4_Q8) begin
            n_sector = SEC_OBTUSE;
        end else begin
            n_sector = SEC_OPPOSITE;
        end

        // Zero-length vector: drop the angle and the sector
        if (i_ctl.degen) begin
            n_angle  = '0;
            n_sector = SEC_NEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle  <= n_angle;
            r_sector <= n_sector;
            r_degen  <= i_ctl.degen;
        end
    end

    assign o_valid  = r_valid;
    assign o_angle  = r_angle;
    assign o_sector = r_sector;
    assign o_degen  = r_degen;

endmodule

@@ sv/vector_angle_octant_core.sv @@
// Top level of the vector angle core: front end, CORDIC cell chain, output stage.
// Depends on voa_pkg, voa_ifs, voa_prep, voa_cell and voa_post.
//
// Usage:
//   i_req carries a request: two signed vectors (start_x, start_y, end_x, end_y).
//   o_res returns one result per request: the unsigned angle between the vectors
//   in degrees (Q8.8, 0 to 180), a 45-degree sector code and a degenerate flag
//   that is set, with angle and sector zero, when either vector has zero length.
//   The pipeline registers the four products, then the start vector formed
//   from dot/cross, then the output of each CORDIC cell, then the clamped and
//   rounded result. Throughput is one request per cycle while the receiver
//   takes results; with one iteration per CORDIC cell, the pipeline holds up
//   to CORDIC_STEPS + 3 requests in flight, with CORDIC_STEPS capped at 24.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   i_req.ready drops; requests are taken again as soon as the result is taken.
//   Reset (synchronous, active low) empties the pipeline; no state survives
//   between requests.
module vector_angle_octant_core #(
    parameter int COORD_BITS   = 12,
    parameter int CORDIC_STEPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    voa_in_if.sink     i_req,
    voa_out_if.source  o_res
);
    import voa_pkg::*;

    localparam int XW    = 2 * COORD_BITS + 3;
    localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    logic                 w_adv;
    t_ctl                 w_ctl [NSTEP+1];
    logic signed [XW-1:0] w_x   [NSTEP+1];
    logic signed [XW-1:0] w_y   [NSTEP+1];
    logic signed [ZW-1:0] w_z   [NSTEP+1];

    // Advance everything while the result register is free or being taken
    assign w_adv       = !o_res.valid || o_res.ready;
    assign i_req.ready = w_adv;

    voa_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_req.valid),
        .i_sx    (i_req.start_x),
        .i_sy    (i_req.start_y),
        .i_ex    (i_req.end_x),
        .i_ey    (i_req.end_y),
        .o_ctl   (w_ctl[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0])
    );

    for (genvar g = 0; g < NSTEP; g++) begin : g_cell
        voa_cell #(
            .XW   (XW),
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    voa_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_ctl    (w_ctl[NSTEP]),
        .i_z      (w_z[NSTEP]),
        .o_valid  (o_res.valid),
        .o_angle  (o_res.angle_deg),
        .o_sector (o_res.sector),
        .o_degen  (o_res.degenerate)
    );

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.degenerate |-> o_res.angle_deg == '0 && o_res.sector == SEC_NEAR)
        else $error("degenerate result carries a nonzero angle or sector");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.angle_deg <= ANGLE_MAX_Q8)
        else $error("angle above 180 degrees");

    a_sector_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.angle_deg < SECT1_Q8) |-> o_res.sector == SEC_NEAR)
        else $error("sector does not match a small angle");

endmodule

@@ tb/vector_angle_octant_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench for vector_angle_octant_core: drives vector pairs on i_req, predicts angle,
// sector and degenerate flag with a CORDIC model of its own and checks every o_res result.
// Depends on voa_pkg, voa_ifs and the core RTL.
module vector_angle_octant_core_tb;
    import voa_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int PIPE_DEPTH   = CORDIC_STEPS + 3;
    localparam int LIMIT_CYCLES = 800000;
    localparam int MAX_PRINTS   = 40;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [SECT_W-1:0]  sector;
        logic               degenerate;
    } t_angle_result;

    logic i_clk;
    logic i_rst_n;

    voa_in_if #(.COORD_BITS(COORD_BITS)) req_if ();
    voa_out_if                           res_if ();

    vector_angle_octant_core #(
        .COORD_BITS  (COORD_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    // atan(2^-i) in degrees, 16 fractional bits
    longint atan_deg_tbl [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    t_angle_result pending_angles[$];
    int            err_count;
    int            results_seen;
    int            degenerate_seen;
    int            sector_hits [0:4];
    int            cycle_count;
    bit            idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_angle_result compute_angle(input t_coord sx, input t_coord sy,
                                                    input t_coord ex, input t_coord ey);
        t_angle_result r;
        longint        dot, crs, x, y, z, nx, ang;
        int            steps;
        r = '0;
        if ((sx == 0 && sy == 0) || (ex == 0 && ey == 0)) begin
            r.degenerate = 1'b1;
            r.sector     = SEC_NEAR;
            return r;
        end
        dot = longint'(sx) * longint'(ex) + longint'(sy) * longint'(ey);
        crs = longint'(sx) * longint'(ey) - longint'(sy) * longint'(ex);
        if (crs < 0) crs = -crs;
        // turn by 90 degrees first when the angle is obtuse
        if (dot < 0) begin
            x = crs;
            y = -dot;
            z = 64'sd5898240;
        end else begin
            x = dot;
            y = crs;
            z = 0;
        end
        steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (int i = 0; i < steps; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_deg_tbl[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_deg_tbl[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > 64'sd11796480) z = 64'sd11796480;
        ang = (z + 128) >>> 8;
        if (ang > longint'(ANGLE_MAX_Q8)) ang = longint'(ANGLE_MAX_Q8);
        r.angle = ang[ANGLE_W-1:0];
        if (ang < longint'(SECT1_Q8))      r.sector = SEC_NEAR;
        else if (ang < longint'(SECT2_Q8)) r.sector = SEC_ACUTE;
        else if (ang < longint'(SECT3_Q8)) r.sector = SEC_RIGHT;
        else if (ang < longint'(SECT4_Q8)) r.sector = SEC_OBTUSE;
        else                               r.sector = SEC_OPPOSITE;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        err_count++;
    endtask

    // Send one request; leave valid high so back-to-back requests stream.
    task automatic send_pair(input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey);
        t_angle_result predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.start_x <= sx;
        req_if.start_y <= sy;
        req_if.end_x   <= ex;
        req_if.end_y   <= ey;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = compute_angle(sx, sy, ex, ey);
        pending_angles.insert(pending_angles.size(), predicted);
    endtask

    // Result sink: random stall bursts while idling is on
    initial begin : result_sink
        int n;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_angle_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_angles.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want = pending_angles.pop_front();
                if (res_if.angle_deg !== want.angle)
                    report_mismatch("angle_deg", int'(res_if.angle_deg), int'(want.angle));
                if (res_if.sector !== want.sector)
                    report_mismatch("sector", int'(res_if.sector), int'(want.sector));
                if (res_if.degenerate !== want.degenerate)
                    report_mismatch("degenerate", int'(res_if.degenerate),
                                    int'(want.degenerate));
                if (want.degenerate) degenerate_seen++;
                else if (want.sector <= SEC_OPPOSITE) sector_hits[want.sector]++;
            end
            results_seen++;
        end
    end

    function automatic t_coord pick_coord(input int unsigned style);
        case (style)
            0: return t_coord'($urandom);
            1: return t_coord'(int'($urandom_range(0, 16)) - 8);
            default: begin
                case ($urandom_range(0, 5))
                    0: return t_coord'(-2048);
                    1: return t_coord'(2047);
                    2: return t_coord'(0);
                    3: return t_coord'(1);
                    4: return t_coord'(-1);
                    default: return t_coord'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic test_zero_length();
        send_pair(0, 0, 100, -50);
        send_pair(-2048, 2047, 0, 0);
        send_pair(0, 0, 0, 0);
        send_pair(1, 0, 0, 0);
    endtask

    task automatic test_extreme_vectors();
        send_pair(2047, 0, 2047, 0);          // identical, zero angle
        send_pair(-2048, 0, 2047, 0);         // opposite along x
        send_pair(-2048, -2048, 2047, 2047);  // opposite along the diagonal, large products
        send_pair(-2048, -2048, -2048, -2048);
        send_pair(0, 2047, 2047, 0);          // right angle, dot exactly zero
        send_pair(1, 0, 0, -1);
        send_pair(1, 0, -1, -1);              // obtuse, starts from 90 degrees
        send_pair(1, 0, -1, 0);               // smallest opposite pair
        send_pair(-1, -1, 2047, -2048);
    endtask

    // Probe each sector boundary from both sides
    task automatic test_sector_edges();
        send_pair(2000, 0, 1848, 763);
        send_pair(2000, 0, 1848, 765);
        send_pair(2000, 0, 1848, 767);
        send_pair(2000, 0, 765, 1846);
        send_pair(2000, 0, 763, 1848);
        send_pair(2000, 0, 767, 1848);
        send_pair(2000, 0, -765, 1848);
        send_pair(2000, 0, -763, 1848);
        send_pair(2000, 0, -767, 1848);
        send_pair(2000, 0, -1848, 763);
        send_pair(2000, 0, -1848, 765);
        send_pair(2000, 0, -1848, 767);
    endtask

    task automatic test_random_pairs(input int count, input bit with_idle);
        t_coord      sx, sy, ex, ey;
        int unsigned style, shape;
        idle_on = with_idle;
        repeat (count) begin
            style = $urandom_range(0, 5);
            style = (style < 3) ? 0 : style - 2;
            sx    = pick_coord(style);
            sy    = pick_coord(style);
            shape = $urandom_range(0, 9);
            case (shape)
                6: begin ex = -sx; ey = -sy; end
                7: begin ex = sx;  ey = sy;  end
                8: begin ex = -sy; ey = sx;  end
                9: begin
                    ex = -sy + t_coord'(int'($urandom_range(0, 4)) - 2);
                    ey = sx;
                end
                default: begin ex = pick_coord(style); ey = pick_coord(style); end
            endcase
            send_pair(sx, sy, ex, ey);
        end
    endtask

    initial begin
        err_count       = 0;
        results_seen    = 0;
        degenerate_seen = 0;
        sector_hits     = '{default: 0};
        idle_on         = 1'b1;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.start_x <= '0;
        req_if.start_y <= '0;
        req_if.end_x   <= '0;
        req_if.end_y   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_extreme_vectors();
        test_sector_edges();
        test_random_pairs(1000, 1'b1);
        test_random_pairs(200, 1'b0);
        test_random_pairs(500, 1'b1);
        test_random_pairs(300, 1'b0);

        req_if.valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);

        $display("Checked %0d angle results, %0d with a zero-length vector.",
                 results_seen, degenerate_seen);
        $display("Sector hits near/acute/right/obtuse/opposite: %0d/%0d/%0d/%0d/%0d",
                 sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
                 sector_hits[4]);
        if (err_count == 0 && pending_angles.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/voa_pkg.sv
sv/voa_ifs.sv
sv/voa_prep.sv
sv/voa_cell.sv
sv/voa_post.sv
sv/vector_angle_octant_core.sv
tb/vector_angle_octant_core_tb.sv
